FILE: rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and codes of the three-class priority queue
// Request and response beat layouts, class, command and status codes, and
// the control word broadcast to every storage cell.
// ----------------------------------------------------------------------------
package tcpq_pkg;

	// field widths of the request and response beats
	localparam int ORDER_W = 16;
	localparam int CLASS_W = 2;
	localparam int STATUS_W = 2;

	// commands
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// classes, highest priority first
	localparam logic [CLASS_W-1:0] CLS_VIP    = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_CLIENT = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_NON    = 2'd2;

	// response status
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               command;
		logic [CLASS_W-1:0] entry_class;
		logic [ORDER_W-1:0] order_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CLASS_W-1:0]  out_class;
		logic [ORDER_W-1:0]  out_order;
		logic                out_valid;
	} rsp_t;

	// control word seen by every cell in the chain
	typedef struct packed {
		logic               enq;
		logic               deq;
		logic [CLASS_W-1:0] cls;
	} cell_ctl_t;

endpackage

FILE: rtl/tcpq_cell.sv
// ----------------------------------------------------------------------------
// tcpq_cell: one slot of the sorted entry chain
// Holds one entry (valid, class, order value). On insert it keeps its entry,
// takes the new one, or takes its left neighbor's; on remove it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
module tcpq_cell
	import tcpq_pkg::*;
#(
	parameter int KW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [KW-1:0]      new_val,
	input  logic               prev_keep,
	input  logic               prev_valid,
	input  logic [CLASS_W-1:0] prev_cls,
	input  logic [KW-1:0]      prev_val,
	input  logic               next_valid,
	input  logic [CLASS_W-1:0] next_cls,
	input  logic [KW-1:0]      next_val,
	output logic               keep,
	output logic               valid,
	output logic [CLASS_W-1:0] cls,
	output logic [KW-1:0]      val
);

	logic               valid_q;
	logic [CLASS_W-1:0] cls_q;
	logic [KW-1:0]      val_q;

	// an entry of equal or higher priority stays ahead of the new one
	assign keep = valid_q && (cls_q <= ctl.cls);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.deq) begin
			valid_q <= next_valid;
		end else if (ctl.enq && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			cls_q <= next_cls;
			val_q <= next_val;
		end else if (ctl.enq && !keep) begin
			if (prev_keep) begin
				cls_q <= ctl.cls;
				val_q <= new_val;
			end else begin
				cls_q <= prev_cls;
				val_q <= prev_val;
			end
		end
	end

	assign valid = valid_q;
	assign cls   = cls_q;
	assign val   = val_q;

endmodule

FILE: rtl/three_class_priority_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue: strict-priority queue, three classes
// Sorted chain of cells, fill counts per class, registered response.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one response beat. Entries live in a chain
// of 3*CLASS_DEPTH cells kept sorted by class (VIP, client, non-client) and by
// arrival within a class, so the head cell always holds the next entry to
// leave. An enqueue shifts the cells behind its insert point one place back,
// a dequeue shifts the whole chain one place forward; both finish in the
// accepting cycle, so the block takes one request per cycle while it is not
// stalled, and the response is loaded into the response register at
// acceptance. The only wait is backpressure: a new request is taken while
// the response register is empty or being drained. Class code three is
// stored as non-client. Order values keep their low ORDER_WIDTH bits, at
// most ORDER_W. There is no clearing pass after reset.
module three_class_priority_queue
	import tcpq_pkg::*;
#(
	parameter int CLASS_DEPTH = 16,
	parameter int ORDER_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int NCLS  = 3;
	localparam int NCELL = NCLS * CLASS_DEPTH;
	localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
	localparam int KW    = (ORDER_WIDTH < ORDER_W) ? ORDER_WIDTH : ORDER_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CLASS_DEPTH);

	logic               take;
	logic [CLASS_W-1:0] cls_eff;
	logic [NCLS-1:0]    full_vec;
	logic               full;
	logic               empty;
	cell_ctl_t          ctl;
	logic [KW-1:0]      new_val;
	rsp_t               rsp_d;

	logic [CNT_W-1:0]   fill_q [NCLS];
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic               cell_keep  [NCELL];
	logic               cell_valid [NCELL];
	logic [CLASS_W-1:0] cell_cls   [NCELL];
	logic [KW-1:0]      cell_val   [NCELL];

	// request handshake
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take      = req_valid && req_ready;

	// class mapping and full / empty flags
	assign cls_eff = (req.entry_class > CLS_NON) ? CLS_NON : req.entry_class;
	always_comb begin
		for (int k = 0; k < NCLS; k++) begin
			full_vec[k] = (fill_q[k] == CNT_FULL);
		end
	end
	assign full    = full_vec[cls_eff];
	assign empty   = !cell_valid[0];
	assign new_val = req.order_value[KW-1:0];

	// control word broadcast to the chain
	always_comb begin
		ctl.enq = take && (req.command == CMD_ENQ) && !full;
		ctl.deq = take && (req.command == CMD_DEQ) && !empty;
		ctl.cls = cls_eff;
	end

	// fill counts per class
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NCLS; k++) begin
				fill_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < NCLS; k++) begin
				if (ctl.enq && (cls_eff == CLASS_W'(k))) begin
					fill_q[k] <= fill_q[k] + CNT_W'(1);
				end else if (ctl.deq && (cell_cls[0] == CLASS_W'(k))) begin
					fill_q[k] <= fill_q[k] - CNT_W'(1);
				end
			end
		end
	end

	// chain of cells, head at index 0
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic               p_keep;
		logic               p_valid;
		logic [CLASS_W-1:0] p_cls;
		logic [KW-1:0]      p_val;
		logic               n_valid;
		logic [CLASS_W-1:0] n_cls;
		logic [KW-1:0]      n_val;

		if (i == 0) begin : g_first
			assign p_keep  = 1'b1;
			assign p_valid = 1'b0;
			assign p_cls   = CLS_VIP;
			assign p_val   = '0;
		end else begin : g_mid
			assign p_keep  = cell_keep[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_cls   = cell_cls[i-1];
			assign p_val   = cell_val[i-1];
		end

		if (i == NCELL - 1) begin : g_last
			assign n_valid = 1'b0;
			assign n_cls   = CLS_VIP;
			assign n_val   = '0;
		end else begin : g_inner
			assign n_valid = cell_valid[i+1];
			assign n_cls   = cell_cls[i+1];
			assign n_val   = cell_val[i+1];
		end

		tcpq_cell #(
			.KW(KW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_val    (new_val),
			.prev_keep  (p_keep),
			.prev_valid (p_valid),
			.prev_cls   (p_cls),
			.prev_val   (p_val),
			.next_valid (n_valid),
			.next_cls   (n_cls),
			.next_val   (n_val),
			.keep       (cell_keep[i]),
			.valid      (cell_valid[i]),
			.cls        (cell_cls[i]),
			.val        (cell_val[i])
		);
	end

	// response word
	always_comb begin
		rsp_d.status    = ST_DONE;
		rsp_d.out_class = CLS_VIP;
		rsp_d.out_order = '0;
		rsp_d.out_valid = 1'b0;
		if (req.command == CMD_ENQ) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.out_class = cell_cls[0];
			rsp_d.out_order = ORDER_W'(cell_val[0]);
			rsp_d.out_valid = 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/tcpq_checker.sv
// ----------------------------------------------------------------------------
// tcpq_checker: port-level checks of the priority queue
// Watches the request and response channels and flags inconsistent beats.
// ----------------------------------------------------------------------------
module tcpq_checker
	import tcpq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// no request is taken while a response is stalled
	a_req_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken over a stalled response");

	// a dequeued entry comes with done status and a real class
	a_deq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_valid |-> rsp.status == ST_DONE && rsp.out_class <= CLS_NON)
		else $error("dequeued entry with bad status or class");

	// no entry: class and order read as zero
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.out_valid |-> rsp.out_class == CLS_VIP && rsp.out_order == '0)
		else $error("empty response carries data");

endmodule

bind three_class_priority_queue tcpq_checker u_tcpq_checker (.*);
